/* hdl/mexp_pkg.sv */
package mexp_pkg;

    // Field widths of the words on the two channels and of the register port.
    localparam int unsigned FIELD_W = 32;

    // Register indexes on the configuration port.
    typedef enum logic [0:0] {
        REG_MODULUS  = 1'b0,
        REG_EXPONENT = 1'b1
    } t_reg_idx;

    // Sequencer states of the exponentiation control.
    typedef enum logic [2:0] {
        S_IDLE,
        S_REDUCE,
        S_MULACC,
        S_SQUARE,
        S_DONE
    } t_state;

    // Ripple signals handed from one cell to the next higher cell.
    typedef struct packed {
        logic carry;   // carry of t = 2r + a
        logic bw1;     // borrow of t - n
        logic bw2;     // borrow of t - 2n
    } t_chain;

    // Result selection broadcast back into every cell.
    typedef struct packed {
        logic use_d2;
        logic use_d1;
    } t_sel;

    // Control from the sequencer to the modular multiplier.
    typedef struct packed {
        logic start;
    } t_mm_ctrl;

    // Status from the modular multiplier to the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } t_mm_stat;

endpackage

/* hdl/mexp_base_if.sv */
interface mexp_base_if;
    import mexp_pkg::*;

    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] base_value;

    modport source (output valid, output base_value, input ready);
    modport sink   (input valid, input base_value, output ready);
endinterface

/* hdl/mexp_result_if.sv */
interface mexp_result_if;
    import mexp_pkg::*;

    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] power_result;

    modport source (output valid, output power_result, input ready);
    modport sink   (input valid, input power_result, output ready);
endinterface

/* hdl/mexp_cell.sv */
module mexp_cell
    import mexp_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_clr,
    input  logic   i_en,
    input  logic   i_r_low,   // remainder bit of the lower neighbor (doubling)
    input  logic   i_a,       // multiplicand bit
    input  logic   i_m,       // current multiplier bit, shared by all cells
    input  logic   i_n,       // modulus bit
    input  logic   i_n_low,   // modulus bit one place lower (for 2n)
    input  t_chain i_chain,
    input  t_sel   i_sel,
    output t_chain o_chain,
    output logic   o_r
);

    logic r_bit;
    logic n_bit;
    logic a_eff;
    logic t_bit;
    logic d1_bit;
    logic d2_bit;

    always_comb begin
        a_eff  = i_a & i_m;
        t_bit  = i_r_low ^ a_eff ^ i_chain.carry;
        d1_bit = t_bit ^ i_n ^ i_chain.bw1;
        d2_bit = t_bit ^ i_n_low ^ i_chain.bw2;
        o_chain.carry = (i_r_low & a_eff) | (i_r_low & i_chain.carry)
                      | (a_eff & i_chain.carry);
        o_chain.bw1 = (~t_bit & (i_n | i_chain.bw1)) | (i_n & i_chain.bw1);
        o_chain.bw2 = (~t_bit & (i_n_low | i_chain.bw2)) | (i_n_low & i_chain.bw2);
        if (i_sel.use_d2) begin
            n_bit = d2_bit;
        end else if (i_sel.use_d1) begin
            n_bit = d1_bit;
        end else begin
            n_bit = t_bit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_clr) begin
            r_bit <= 1'b0;
        end else if (i_en) begin
            r_bit <= n_bit;
        end
    end

    assign o_r = r_bit;

endmodule

/* hdl/mexp_mulmod.sv */
module mexp_mulmod
    import mexp_pkg::*;
#(
    parameter int unsigned W = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_mm_ctrl     i_ctrl,
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_m,
    input  logic [W-1:0] i_n,
    output t_mm_stat     o_stat,
    output logic [W-1:0] o_r
);

    // Two extra cells hold the headroom of 2r + a before reduction.
    localparam int unsigned CELLS = W + 2;
    localparam int unsigned CNT_W = $clog2(W + 1);

    logic [W-1:0]     r_mult;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [CELLS-1:0] cell_r;
    logic [CELLS-1:0] cell_a;
    logic [CELLS-1:0] cell_n;
    logic [CELLS-1:0] cell_n_low;
    logic [CELLS-1:0] cell_r_low;
    t_chain           chain [CELLS+1];
    t_sel             sel;

    assign cell_a     = {2'b00, i_a};
    assign cell_n     = {2'b00, i_n};
    assign cell_n_low = {1'b0, i_n, 1'b0};
    assign cell_r_low = {cell_r[CELLS-2:0], 1'b0};
    assign chain[0]   = '0;

    // Keep the smallest of t, t - n, t - 2n that does not go negative.
    always_comb begin
        sel.use_d2 = ~chain[CELLS].bw2;
        sel.use_d1 = chain[CELLS].bw2 & ~chain[CELLS].bw1;
    end

    for (genvar k = 0; k < CELLS; k++) begin : g_cell
        mexp_cell u_cell (
            .i_clk   (i_clk),
            .i_clr   (i_ctrl.start),
            .i_en    (r_busy),
            .i_r_low (cell_r_low[k]),
            .i_a     (cell_a[k]),
            .i_m     (r_mult[W-1]),
            .i_n     (cell_n[k]),
            .i_n_low (cell_n_low[k]),
            .i_chain (chain[k]),
            .i_sel   (sel),
            .o_chain (chain[k+1]),
            .o_r     (cell_r[k])
        );
    end

    // Multiplier bits are consumed most significant first, one per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctrl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.start) begin
            r_mult <= i_m;
        end else if (r_busy) begin
            r_mult <= {r_mult[W-2:0], 1'b0};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_r         = cell_r[W-1:0];

endmodule

/* hdl/modular_exponentiation_unit.sv */
// Channel   | Dir | Word          | Meaning
// ----------+-----+---------------+------------------------------------------
// base_if   | in  | base_value    | base to raise to the configured exponent
// result_if | out | power_result  | base ^ exponent mod modulus
// cfg       | in  | i_cfg_idx/dat | 0: modulus, 1: exponent (write only)
//
// One word at a time. Each modular product runs in the shared cell row as a
// start step, one step per multiplier bit and a done step; a word costs one
// reduction plus, per exponent bit up to the highest set one, one square and
// one multiply when the bit is set.
// Reset is synchronous and active low; both registers return to 1.
// A finished word waits in the output register; a new base is taken while it
// waits, and the sequencer only stalls if a second result is ready first.
module modular_exponentiation_unit
    import mexp_pkg::*;
#(
    parameter int unsigned OPERAND_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [0:0]         i_cfg_idx,
    input  logic [FIELD_W-1:0] i_cfg_data,
    mexp_base_if.sink          base_if,
    mexp_result_if.source      result_if
);

    localparam int unsigned W = OPERAND_WIDTH;

    logic [FIELD_W-1:0] r_modulus;
    logic [FIELD_W-1:0] r_exponent;

    t_state       r_state;
    t_state       n_state;
    logic [W-1:0] r_base;
    logic [W-1:0] n_base;
    logic [W-1:0] r_acc;
    logic [W-1:0] n_acc;
    logic [W-1:0] r_exp;
    logic [W-1:0] n_exp;
    logic         r_start;
    logic         n_start;
    logic         r_out_valid;
    logic         n_out_valid;
    logic [FIELD_W-1:0] r_out_data;
    logic [FIELD_W-1:0] n_out_data;

    logic [W-1:0] mod_n;
    logic [W-1:0] mm_a;
    logic [W-1:0] mm_m;
    logic [W-1:0] mm_r;
    logic         mod_is_zero;
    logic         mod_is_one;
    logic         in_fire;
    t_mm_ctrl     mm_ctrl;
    t_mm_stat     mm_stat;

    assign mod_n       = r_modulus[W-1:0];
    assign mod_is_zero = (mod_n == '0);
    assign mod_is_one  = (mod_n == W'(1));
    assign in_fire     = base_if.valid & base_if.ready;

    // Configuration registers; an index past the list does not exist.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus  <= FIELD_W'(1);
            r_exponent <= FIELD_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_MODULUS:  r_modulus  <= i_cfg_data;
                REG_EXPONENT: r_exponent <= i_cfg_data;
                default:      ;
            endcase
        end
    end

    // The reduction of the base is a product with 1 and the raw base as the
    // multiplier; squares use the base as both operands.
    always_comb begin
        mm_a = r_base;
        mm_m = r_base;
        case (r_state)
            S_REDUCE: mm_a = W'(1);
            S_MULACC: mm_m = r_acc;
            default:  ;
        endcase
    end

    assign mm_ctrl.start = r_start;

    mexp_mulmod #(.W(W)) u_mulmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (mm_ctrl),
        .i_a     (mm_a),
        .i_m     (mm_m),
        .i_n     (mod_n),
        .o_stat  (mm_stat),
        .o_r     (mm_r)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_start     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_start     <= n_start;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_base     <= n_base;
        r_acc      <= n_acc;
        r_exp      <= n_exp;
        r_out_data <= n_out_data;
    end

    // Sequencer. After the base is reduced the exponent is walked from its
    // low end; the walk stops as soon as no set bit remains, since the
    // later squares no longer change the accumulator.
    always_comb begin
        n_state     = r_state;
        n_start     = 1'b0;
        n_base      = r_base;
        n_acc       = r_acc;
        n_exp       = r_exp;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;

        if (result_if.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_base = base_if.base_value[W-1:0];
                    n_exp  = r_exponent[W-1:0];
                    n_acc  = mod_is_one ? '0 : W'(1);
                    if (mod_is_zero) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_REDUCE;
                        n_start = 1'b1;
                    end
                end
            end
            S_REDUCE: begin
                if (mm_stat.done) begin
                    n_base = mm_r;
                    if (r_exp == '0) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = r_exp[0] ? S_MULACC : S_SQUARE;
                        n_start = 1'b1;
                    end
                end
            end
            S_MULACC: begin
                if (mm_stat.done) begin
                    n_acc   = mm_r;
                    n_state = S_SQUARE;
                    n_start = 1'b1;
                end
            end
            S_SQUARE: begin
                if (mm_stat.done) begin
                    n_base = mm_r;
                    n_exp  = {1'b0, r_exp[W-1:1]};
                    if (r_exp[W-1:1] == '0) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = r_exp[1] ? S_MULACC : S_SQUARE;
                        n_start = 1'b1;
                    end
                end
            end
            S_DONE: begin
                if (!r_out_valid || result_if.ready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = mod_is_zero ? '0 : FIELD_W'(r_acc);
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign base_if.ready          = (r_state == S_IDLE);
    assign result_if.valid        = r_out_valid;
    assign result_if.power_result = r_out_data;

endmodule

/* hdl/mexp_checker.sv */
module mexp_checker
    import mexp_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic [FIELD_W-1:0] out_data
);

    // A result that is not taken stays offered with the same value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result dropped or changed while stalled");

    // Only one base is in flight: after taking one the input closes.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second base taken while one is in flight");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !out_valid)
        else $error("result pending after reset");

    // A new result never appears in the cycle right after a base is taken.
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready && (!out_valid || out_ready) |=> !out_valid)
        else $error("result produced without computation");

endmodule

bind modular_exponentiation_unit mexp_checker u_mexp_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .in_valid  (base_if.valid),
    .in_ready  (base_if.ready),
    .out_valid (result_if.valid),
    .out_ready (result_if.ready),
    .out_data  (result_if.power_result)
);
